// ----- hw/rtl/bdeh_pkg.sv -----
// Shared types and constants for the button debouncer with press-edge holdoff.
// Used by the lane, the merge stage and the top level; depends on nothing.
package bdeh_pkg;

    localparam int BUTTONS_DEF   = 4;
    localparam int AGE_WIDTH_DEF = 12;

    localparam int PIN_W      = 4;
    localparam int DEBOUNCE_W = 10;
    localparam int HOLDOFF_W  = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(30);
    localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RESET  = HOLDOFF_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_HOLDOFF  = 2'd1
    } cfg_idx_t;

    // What one lane reports for the current tick.
    typedef struct packed {
        logic fire;
        logic stable;
    } lane_res_t;

endpackage

// ----- hw/rtl/bdeh_lane.sv -----
// One button lane: raw level, change age, stable state and pulse holdoff age.
// Depends on bdeh_pkg.
module bdeh_lane import bdeh_pkg::*; #(
    parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  raw_pressed,
    input  logic [DEBOUNCE_W-1:0] debounce_ticks,
    input  logic [HOLDOFF_W-1:0]  holdoff_ticks,
    output lane_res_t             res
);

    localparam int CMP_W = (AGE_WIDTH > HOLDOFF_W) ? AGE_WIDTH : HOLDOFF_W;

    logic                 last_raw_reg, last_raw_next;
    logic [AGE_WIDTH-1:0] change_age_reg, change_age_next;
    logic                 stable_reg, stable_next;
    logic                 prev_stable_reg, prev_stable_next;
    logic [AGE_WIDTH-1:0] pulse_age_reg, pulse_age_next;
    logic [AGE_WIDTH-1:0] change_inc, pulse_inc;
    logic                 fire;

    always_comb begin
        change_inc = (change_age_reg == '1) ? change_age_reg : change_age_reg + 1'b1;
        pulse_inc  = (pulse_age_reg == '1) ? pulse_age_reg : pulse_age_reg + 1'b1;

        last_raw_next   = raw_pressed;
        change_age_next = (raw_pressed != last_raw_reg) ? '0 : change_inc;

        stable_next = stable_reg;
        if (CMP_W'(change_age_next) > CMP_W'(debounce_ticks)) begin
            stable_next = raw_pressed;
        end

        // A press fires only on a rising stable edge once the holdoff has run out.
        fire = stable_next && !prev_stable_reg &&
               (CMP_W'(pulse_inc) > CMP_W'(holdoff_ticks));
        pulse_age_next   = fire ? '0 : pulse_inc;
        prev_stable_next = stable_next;

        res.fire   = fire;
        res.stable = stable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= 1'b0;
            change_age_reg  <= '0;
            stable_reg      <= 1'b0;
            prev_stable_reg <= 1'b0;
            pulse_age_reg   <= '0;
        end else if (step) begin
            last_raw_reg    <= last_raw_next;
            change_age_reg  <= change_age_next;
            stable_reg      <= stable_next;
            prev_stable_reg <= prev_stable_next;
            pulse_age_reg   <= pulse_age_next;
        end
    end

endmodule

// ----- hw/rtl/bdeh_merge.sv -----
// Merge stage: packs the lane results into the output masks and holds the
// result word in the output register. Depends on bdeh_pkg.
module bdeh_merge import bdeh_pkg::*; #(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  lane_res_t        lanes [BUTTONS],
    input  logic             m_ready,
    output logic             m_valid,
    output logic [PIN_W-1:0] m_press_pulses,
    output logic [PIN_W-1:0] m_stable_pressed,
    output logic             can_load
);

    logic             valid_reg;
    logic [PIN_W-1:0] pulses_reg, pulses_next;
    logic [PIN_W-1:0] stable_reg, stable_next;

    // Lanes beyond the output width are dropped; missing lanes read as zero.
    always_comb begin
        pulses_next = '0;
        stable_next = '0;
        for (int j = 0; j < PIN_W; j++) begin
            if (j < BUTTONS) begin
                pulses_next[j] = lanes[j].fire;
                stable_next[j] = lanes[j].stable;
            end
        end
    end

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pulses_reg <= pulses_next;
            stable_reg <= stable_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_press_pulses   = pulses_reg;
    assign m_stable_pressed = stable_reg;

endmodule

// ----- hw/rtl/button_debounce_edge_holdoff.sv -----
// Button debouncer with press-edge detection and per-button pulse holdoff.
// The result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless m_ready stalls; all button lanes update in
// the accept cycle, and the single output register refills in the cycle it is taken.
// Reset: synchronous, active low; restores register defaults and clears lane state.
// Instantiates bdeh_lane and bdeh_merge; depends on bdeh_pkg.
module button_debounce_edge_holdoff import bdeh_pkg::*; #(
    parameter int BUTTONS   = BUTTONS_DEF,
    parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIN_W-1:0]      s_pin_levels,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIN_W-1:0]      m_press_pulses,
    output logic [PIN_W-1:0]      m_stable_pressed,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [HOLDOFF_W-1:0]  holdoff_reg;
    logic                  step;
    logic                  can_load;
    lane_res_t             lanes [BUTTONS];

    assign cfg_ready = 1'b1;
    assign s_ready   = can_load;
    assign step      = s_valid && can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            holdoff_reg  <= HOLDOFF_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE: debounce_reg <= cfg_wdata[DEBOUNCE_W-1:0];
                CFG_HOLDOFF:  holdoff_reg  <= cfg_wdata[HOLDOFF_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
        logic raw_pressed;
        // Pins are active low; buttons without a pin read as pressed.
        if (i < PIN_W) begin : g_pin
            assign raw_pressed = !s_pin_levels[i];
        end else begin : g_nopin
            assign raw_pressed = 1'b1;
        end

        bdeh_lane #(
            .AGE_WIDTH(AGE_WIDTH)
        ) u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .step          (step),
            .raw_pressed   (raw_pressed),
            .debounce_ticks(debounce_reg),
            .holdoff_ticks (holdoff_reg),
            .res           (lanes[i])
        );
    end

    bdeh_merge #(
        .BUTTONS(BUTTONS)
    ) u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (step),
        .lanes           (lanes),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_press_pulses  (m_press_pulses),
        .m_stable_pressed(m_stable_pressed),
        .can_load        (can_load)
    );

    // A press pulse always comes with that button's stable pressed state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_press_pulses & ~m_stable_pressed) == '0))
        else $error("press pulse without stable pressed state");

    // Every accepted word produces a result word in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted word produced no result");

    // Reset leaves the output register empty.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word pending right after reset");

endmodule
